// File: design/sef_pkg.sv
// sef_pkg: shared types, codes and text tables for the sse event framer
// used by sef_plan, sef_emit and the top level; depends on nothing
`timescale 1ns / 1ps

package sef_pkg;

	// default number of bytes held for the event name and for the id
	localparam int FIELD_MAX_DEF = 16;

	// input operation codes
	typedef enum logic [2:0] {
		OP_EVT_BYTE = 3'd0,
		OP_ID_BYTE  = 3'd1,
		OP_DATA     = 3'd2,
		OP_CMT      = 3'd3,
		OP_FIN_EVT  = 3'd4,
		OP_FIN_CMT  = 3'd5
	} op_t;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FORBIDDEN = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	// special characters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;

	// fixed texts of the frame
	typedef enum logic [2:0] {
		TXT_EVENT,
		TXT_ID,
		TXT_DATA,
		TXT_DATA_BARE,
		TXT_CMT,
		TXT_CMT_BARE
	} txt_sel_t;

	// emitter sequencer states, in output order
	typedef enum logic [3:0] {
		EM_IDLE,
		EM_EVT_TXT,
		EM_EVT_FLD,
		EM_EVT_NL,
		EM_ID_TXT,
		EM_ID_FLD,
		EM_ID_NL,
		EM_PFX_TXT,
		EM_BODY,
		EM_NL,
		EM_NL2,
		EM_REJECT
	} emit_state_t;

	// what one accepted item asks the emitter to produce
	typedef struct packed {
		logic       hdr_evt;
		logic       hdr_id;
		logic       pfx;
		logic       cmt;
		logic       bare;
		logic       body;
		logic       nl;
		logic       nl2;
		logic       reject;
		logic [1:0] status;
		logic [7:0] body_byte;
	} plan_t;

	// length of a fixed text
	function automatic logic [2:0] txt_len(txt_sel_t sel);
		logic [2:0] len;
		unique case (sel)
			TXT_EVENT:     len = 3'd7;
			TXT_ID:        len = 3'd4;
			TXT_DATA:      len = 3'd6;
			TXT_DATA_BARE: len = 3'd5;
			TXT_CMT:       len = 3'd2;
			TXT_CMT_BARE:  len = 3'd1;
			default:       len = 3'd1;
		endcase
		return len;
	endfunction

	// one character of a fixed text, texts stored left aligned
	function automatic logic [7:0] txt_char(txt_sel_t sel, logic [2:0] idx);
		logic [55:0] s;
		logic [55:0] sh;
		unique case (sel)
			TXT_EVENT:     s = "event: ";
			TXT_ID:        s = {"id: ", 24'h0};
			TXT_DATA:      s = {"data: ", 8'h0};
			TXT_DATA_BARE: s = {"data:", 16'h0};
			TXT_CMT:       s = {": ", 40'h0};
			TXT_CMT_BARE:  s = {":", 48'h0};
			default:       s = 56'h0;
		endcase
		sh = s << {idx, 3'b000};
		return sh[55:48];
	endfunction

endpackage

// File: design/sef_field_mem.sv
// sef_field_mem: synchronous store for event name and id bytes
// one write port, one read port with registered data; uses no package
`timescale 1ns / 1ps

module sef_field_mem #(
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/sef_plan.sv
// sef_plan: input transfer, frame state and per-item output plan
// writes field bytes into the field store; uses sef_pkg
`timescale 1ns / 1ps

module sef_plan #(
	parameter int FIELD_MAX = sef_pkg::FIELD_MAX_DEF,
	localparam int LEN_W = $clog2(FIELD_MAX + 1),
	localparam int AW = $clog2(2 * FIELD_MAX)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          op,
	input  logic [7:0]          in_byte,
	input  logic                free,
	input  logic                take,
	output logic                plan_valid,
	output sef_pkg::plan_t      plan,
	output logic [LEN_W-1:0]    evt_len,
	output logic [LEN_W-1:0]    id_len,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [7:0]          wr_data
);

	logic [LEN_W-1:0] evt_cnt_q, id_cnt_q, evt_cnt_d, id_cnt_d;
	logic [1:0]       reject_q, reject_d;
	logic             hdr_done_q, hdr_done_d;
	logic             line_start_q, line_start_d;
	logic             pend_cr_q, pend_cr_d;
	logic             plan_valid_q;
	logic             plan_go;
	logic             accept;
	logic             is_id;
	logic             is_term;
	logic             skip_lf;
	logic [LEN_W-1:0] cur_len;
	sef_pkg::plan_t   plan_c, plan_q;
	logic [LEN_W-1:0] evt_len_s1, id_len_s1;

	assign in_ready = !plan_valid_q && free;
	assign accept   = in_valid && in_ready;

	assign is_id   = (sef_pkg::op_t'(op) == sef_pkg::OP_ID_BYTE);
	assign cur_len = is_id ? id_cnt_q : evt_cnt_q;
	assign is_term = (in_byte == sef_pkg::CH_CR) || (in_byte == sef_pkg::CH_LF);
	assign skip_lf = pend_cr_q && (in_byte == sef_pkg::CH_LF);

	// decode the item: next frame state, plan and field store write
	always_comb begin
		evt_cnt_d    = evt_cnt_q;
		id_cnt_d     = id_cnt_q;
		reject_d     = reject_q;
		hdr_done_d   = hdr_done_q;
		line_start_d = line_start_q;
		pend_cr_d    = pend_cr_q;
		plan_c       = '0;
		plan_c.body_byte = in_byte;
		plan_c.status    = reject_q;
		plan_go      = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = (is_id ? AW'(FIELD_MAX) : AW'(0)) + AW'(cur_len);
		wr_data      = in_byte;
		unique case (sef_pkg::op_t'(op)) inside
			sef_pkg::OP_EVT_BYTE, sef_pkg::OP_ID_BYTE: begin
				if (reject_q == sef_pkg::ST_OK && !hdr_done_q) begin
					if (is_term || in_byte == sef_pkg::CH_NUL) begin
						reject_d = sef_pkg::ST_FORBIDDEN;
					end else if (cur_len >= LEN_W'(FIELD_MAX)) begin
						reject_d = sef_pkg::ST_TOO_LONG;
					end else begin
						wr_en = accept;
						if (is_id) begin
							id_cnt_d = id_cnt_q + LEN_W'(1);
						end else begin
							evt_cnt_d = evt_cnt_q + LEN_W'(1);
						end
					end
				end
			end
			sef_pkg::OP_DATA, sef_pkg::OP_CMT: begin
				if (reject_q == sef_pkg::ST_OK) begin
					plan_c.hdr_evt = !hdr_done_q && (evt_cnt_q != '0);
					plan_c.hdr_id  = !hdr_done_q && (id_cnt_q != '0);
					plan_c.cmt     = (sef_pkg::op_t'(op) == sef_pkg::OP_CMT);
					hdr_done_d     = 1'b1;
					pend_cr_d      = 1'b0;
					if (!skip_lf) begin
						plan_c.pfx = line_start_q;
						if (is_term) begin
							plan_c.bare  = 1'b1;
							plan_c.nl    = 1'b1;
							line_start_d = 1'b1;
							pend_cr_d    = (in_byte == sef_pkg::CH_CR);
						end else begin
							plan_c.body  = 1'b1;
							line_start_d = 1'b0;
						end
					end
					plan_go = plan_c.hdr_evt || plan_c.hdr_id || plan_c.pfx ||
						plan_c.body || plan_c.nl;
				end
			end
			sef_pkg::OP_FIN_EVT, sef_pkg::OP_FIN_CMT: begin
				plan_go = 1'b1;
				if (reject_q != sef_pkg::ST_OK) begin
					plan_c.reject = 1'b1;
				end else begin
					plan_c.hdr_evt = !hdr_done_q && (evt_cnt_q != '0);
					plan_c.hdr_id  = !hdr_done_q && (id_cnt_q != '0);
					plan_c.cmt     = (sef_pkg::op_t'(op) == sef_pkg::OP_FIN_CMT);
					plan_c.pfx     = line_start_q;
					plan_c.bare    = 1'b1;
					plan_c.nl      = 1'b1;
					plan_c.nl2     = 1'b1;
				end
				evt_cnt_d    = '0;
				id_cnt_d     = '0;
				reject_d     = sef_pkg::ST_OK;
				hdr_done_d   = 1'b0;
				line_start_d = 1'b1;
				pend_cr_d    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_cnt_q    <= '0;
			id_cnt_q     <= '0;
			reject_q     <= sef_pkg::ST_OK;
			hdr_done_q   <= 1'b0;
			line_start_q <= 1'b1;
			pend_cr_q    <= 1'b0;
			plan_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				evt_cnt_q    <= evt_cnt_d;
				id_cnt_q     <= id_cnt_d;
				reject_q     <= reject_d;
				hdr_done_q   <= hdr_done_d;
				line_start_q <= line_start_d;
				pend_cr_q    <= pend_cr_d;
				plan_valid_q <= plan_go;
			end else if (take) begin
				plan_valid_q <= 1'b0;
			end
		end
	end

	// plan and length snapshot for the emitter
	always_ff @(posedge clk) begin
		if (accept) begin
			plan_q     <= plan_c;
			evt_len_s1 <= evt_cnt_q;
			id_len_s1  <= id_cnt_q;
		end
	end

	assign plan_valid = plan_valid_q;
	assign plan       = plan_q;
	assign evt_len    = evt_len_s1;
	assign id_len     = id_len_s1;

endmodule

// File: design/sef_emit.sv
// sef_emit: output sequencer and output register of the sse event framer
// reads field bytes from the field store; uses sef_pkg
`timescale 1ns / 1ps

module sef_emit #(
	parameter int FIELD_MAX = sef_pkg::FIELD_MAX_DEF,
	localparam int LEN_W = $clog2(FIELD_MAX + 1),
	localparam int AW = $clog2(2 * FIELD_MAX)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             plan_valid,
	input  sef_pkg::plan_t   plan,
	input  logic [LEN_W-1:0] evt_len,
	input  logic [LEN_W-1:0] id_len,
	output logic             take,
	output logic             free,
	output logic [AW-1:0]    rd_addr,
	input  logic [7:0]       rd_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             has_byte,
	output logic             frame_end,
	output logic [1:0]       status,
	output logic             run_last
);

	localparam int CW = (LEN_W > 3) ? LEN_W : 3;

	sef_pkg::emit_state_t state_q, state_d, succ;
	sef_pkg::emit_state_t first, after_evt, after_id, after_pfx, after_body, after_nl;
	sef_pkg::txt_sel_t    sel;
	logic [CW-1:0]        cnt_q, cnt_d, cnt_succ;
	logic                 advance;
	logic                 txt_last;
	logic                 fld_last;
	logic [7:0]           byte_c;
	logic                 has_c, fe_c;
	logic [1:0]           st_c;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 has_byte_q, frame_end_q, run_last_q;
	logic [1:0]           status_q;

	// text selection for the current state
	always_comb begin
		unique case (state_q)
			sef_pkg::EM_EVT_TXT: sel = sef_pkg::TXT_EVENT;
			sef_pkg::EM_ID_TXT:  sel = sef_pkg::TXT_ID;
			default: begin
				if (plan.cmt) begin
					sel = plan.bare ? sef_pkg::TXT_CMT_BARE : sef_pkg::TXT_CMT;
				end else begin
					sel = plan.bare ? sef_pkg::TXT_DATA_BARE : sef_pkg::TXT_DATA;
				end
			end
		endcase
	end

	assign txt_last = (cnt_q == CW'(sef_pkg::txt_len(sel)) - CW'(1));
	assign fld_last = (state_q == sef_pkg::EM_ID_FLD) ?
		(cnt_q == CW'(id_len) - CW'(1)) : (cnt_q == CW'(evt_len) - CW'(1));
	assign advance  = (state_q != sef_pkg::EM_IDLE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		after_nl   = plan.nl2 ? sef_pkg::EM_NL2 : sef_pkg::EM_IDLE;
		after_body = plan.nl ? sef_pkg::EM_NL : after_nl;
		after_pfx  = plan.body ? sef_pkg::EM_BODY : after_body;
		after_id   = plan.pfx ? sef_pkg::EM_PFX_TXT : after_pfx;
		after_evt  = plan.hdr_id ? sef_pkg::EM_ID_TXT : after_id;
		first      = plan.reject ? sef_pkg::EM_REJECT :
			(plan.hdr_evt ? sef_pkg::EM_EVT_TXT : after_evt);
		unique case (state_q)
			sef_pkg::EM_IDLE:    succ = first;
			sef_pkg::EM_EVT_TXT: succ = txt_last ? sef_pkg::EM_EVT_FLD : sef_pkg::EM_EVT_TXT;
			sef_pkg::EM_EVT_FLD: succ = fld_last ? sef_pkg::EM_EVT_NL : sef_pkg::EM_EVT_FLD;
			sef_pkg::EM_EVT_NL:  succ = after_evt;
			sef_pkg::EM_ID_TXT:  succ = txt_last ? sef_pkg::EM_ID_FLD : sef_pkg::EM_ID_TXT;
			sef_pkg::EM_ID_FLD:  succ = fld_last ? sef_pkg::EM_ID_NL : sef_pkg::EM_ID_FLD;
			sef_pkg::EM_ID_NL:   succ = after_id;
			sef_pkg::EM_PFX_TXT: succ = txt_last ? after_pfx : sef_pkg::EM_PFX_TXT;
			sef_pkg::EM_BODY:    succ = after_body;
			sef_pkg::EM_NL:      succ = after_nl;
			sef_pkg::EM_NL2:     succ = sef_pkg::EM_IDLE;
			sef_pkg::EM_REJECT:  succ = sef_pkg::EM_IDLE;
			default:             succ = sef_pkg::EM_IDLE;
		endcase
		cnt_succ = (succ == state_q) ? cnt_q + CW'(1) : '0;
		if (state_q == sef_pkg::EM_IDLE) begin
			state_d = plan_valid ? first : sef_pkg::EM_IDLE;
			cnt_d   = '0;
		end else if (advance) begin
			state_d = succ;
			cnt_d   = cnt_succ;
		end else begin
			state_d = state_q;
			cnt_d   = cnt_q;
		end
	end

	assign take = (state_q == sef_pkg::EM_IDLE) && plan_valid;
	assign free = (state_q == sef_pkg::EM_IDLE) || (advance && succ == sef_pkg::EM_IDLE);

	// field store address follows the next state so data is ready in time
	always_comb begin
		unique case (state_d)
			sef_pkg::EM_EVT_FLD: rd_addr = AW'(cnt_d);
			sef_pkg::EM_ID_FLD:  rd_addr = AW'(cnt_d) + AW'(FIELD_MAX);
			default:             rd_addr = '0;
		endcase
	end

	// result item of the current state
	always_comb begin
		byte_c = 8'h00;
		has_c  = 1'b1;
		fe_c   = 1'b0;
		st_c   = sef_pkg::ST_OK;
		unique case (state_q) inside
			sef_pkg::EM_EVT_TXT, sef_pkg::EM_ID_TXT, sef_pkg::EM_PFX_TXT:
				byte_c = sef_pkg::txt_char(sel, cnt_q[2:0]);
			sef_pkg::EM_EVT_FLD, sef_pkg::EM_ID_FLD:
				byte_c = rd_data;
			sef_pkg::EM_EVT_NL, sef_pkg::EM_ID_NL, sef_pkg::EM_NL:
				byte_c = sef_pkg::CH_LF;
			sef_pkg::EM_BODY:
				byte_c = plan.body_byte;
			sef_pkg::EM_NL2: begin
				byte_c = sef_pkg::CH_LF;
				fe_c   = 1'b1;
			end
			sef_pkg::EM_REJECT: begin
				has_c = 1'b0;
				fe_c  = 1'b1;
				st_c  = plan.status;
			end
			default: has_c = 1'b0;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sef_pkg::EM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= byte_c;
			has_byte_q  <= has_c;
			frame_end_q <= fe_c;
			status_q    <= st_c;
			run_last_q  <= (succ == sef_pkg::EM_IDLE);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_byte_q;
	assign frame_end = frame_end_q;
	assign status    = status_q;
	assign run_last  = run_last_q;

endmodule

// File: design/sse_event_framer_unit.sv
// sse_event_framer_unit: top level of the sse event framer
// ties together sef_plan, sef_field_mem and sef_emit; uses sef_pkg
`timescale 1ns / 1ps
//
// channel  signals                                           direction
// input    in_valid, in_ready, op, in_byte                   consumer
// output   out_valid, out_ready, out_byte, has_byte,         producer
//          frame_end, status, run_last
//
// an event or id byte only updates frame state and the field store; an item with
// results is registered as a plan, then the output sequencer emits its results,
// one result a cycle while the output is not stalled
// field bytes come from a synchronous store addressed from the sequencer's state_d
// reset clears frame state and the sequencer; the field store is not cleared
// a stalled output holds the sequencer; the next item is taken no earlier
// than the edge that loads the current item's last result into the output register

module sse_event_framer_unit #(
	parameter int FIELD_MAX = sef_pkg::FIELD_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       frame_end,
	output logic [1:0] status,
	output logic       run_last
);

	localparam int LEN_W = $clog2(FIELD_MAX + 1);
	localparam int AW    = $clog2(2 * FIELD_MAX);

	logic             free;
	logic             take;
	logic             plan_valid;
	sef_pkg::plan_t   plan;
	logic [LEN_W-1:0] evt_len;
	logic [LEN_W-1:0] id_len;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       rd_data;

	// input transfer and frame state
	sef_plan #(
		.FIELD_MAX(FIELD_MAX)
	) u_plan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.in_byte   (in_byte),
		.free      (free),
		.take      (take),
		.plan_valid(plan_valid),
		.plan      (plan),
		.evt_len   (evt_len),
		.id_len    (id_len),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// event name bytes then id bytes
	sef_field_mem #(
		.DEPTH(2 * FIELD_MAX)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// output sequencer
	sef_emit #(
		.FIELD_MAX(FIELD_MAX)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.plan_valid(plan_valid),
		.plan      (plan),
		.evt_len   (evt_len),
		.id_len    (id_len),
		.take      (take),
		.free      (free),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.frame_end (frame_end),
		.status    (status),
		.run_last  (run_last)
	);

endmodule
